// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a signal is never unknown outside reset.
`define ASSERT_KNOWN(label, clk, rst_n, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !$isunknown(sig)) \
    else $error(msg);

`endif

// ===== rtl/ltct_pkg.sv =====
// Package for the three-color luma tint: payload types, register codes, defaults.
`default_nettype none
package ltct_pkg;

  localparam int unsigned ColorFracBits = 16;
  localparam int unsigned CfgIdxBits    = 2;
  localparam int unsigned CfgDataBits   = 3 * ColorFracBits;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_BLACK = 2'd0,
    REG_GREY  = 2'd1,
    REG_WHITE = 2'd2,
    REG_POINT = 2'd3
  } reg_idx_e;

  localparam logic [47:0] BlackReset = 48'd75995151368192;
  localparam logic [47:0] GreyReset  = 48'd281470681776128;
  localparam logic [47:0] WhiteReset = 48'd281474976645120;
  localparam logic [15:0] PointReset = 16'd32768;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } pix_out_t;

  typedef struct packed {
    logic [CfgIdxBits-1:0]  idx;
    logic [CfgDataBits-1:0] data;
  } cfg_beat_t;

endpackage
`default_nettype wire

// ===== rtl/luma_three_color_tint.sv =====
// Top level of the three-color luma tint pipeline.
// Pixels enter one per clock while in_ready_o is high; each result passes through
// ten registered stages (one luma stage, five curve and sum stages, four
// two-bit divider stages, the last of which drives the output). Empty stages close up
// under back-pressure; the input stalls only when all ten stages hold data and the
// output is not taken. Configuration is taken at any time and applies to later pixels.
`default_nettype none
module luma_three_color_tint (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ltct_pkg::pix_in_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ltct_pkg::pix_out_t  out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  ltct_pkg::cfg_beat_t cfg_data_i
);
  import ltct_pkg::*;
  localparam int unsigned CW = ColorFracBits;
  localparam int unsigned NS = 10;

  logic [3*CW-1:0] black_w, grey_w, white_w;
  logic [15:0]     point_w;

  assign cfg_ready_o = 1'b1;

  ltct_regs #(.ColorFracBits(CW)) u_regs (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_i(cfg_data_i),
    .black_o(black_w), .grey_o(grey_w), .white_o(white_w), .point_o(point_w)
  );

  // Valid chain: stage k advances when it is empty or the next one moves.
  logic [NS-1:0] vld_q;
  logic [NS-1:0] en_w;
  always_comb begin
    en_w[NS-1] = !vld_q[NS-1] || out_ready_i;
    for (int k = NS-2; k >= 0; k--) en_w[k] = !vld_q[k] || en_w[k+1];
  end
  assign in_ready_o = en_w[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en_w[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en_w[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // Stage 0: luma = floor(weighted sum / 1000) by reciprocal and correction.
  logic [17:0] ws_w;
  logic [35:0] prod_w;
  logic [8:0]  yq_w;
  logic [7:0]  y_q;
  logic [16:0] p_q;
  logic [3*CW-1:0] cb_q, cg_q, cw_q;
  logic [7:0]  a_q [NS];
  always_comb begin
    ws_w = 18'(in_data_i.in_red) * 18'd299 + 18'(in_data_i.in_green) * 18'd587
         + 18'(in_data_i.in_blue) * 18'd114;
    prod_w = 36'(ws_w) * 36'd4194;  // 2^22/1000 rounded down
    yq_w = 9'(prod_w >> 22);
    if (18'(yq_w + 9'd1) * 18'd1000 <= ws_w) yq_w = yq_w + 9'd1;
  end
  always_ff @(posedge clk_i) begin
    if (en_w[0]) begin
      y_q  <= yq_w[7:0];
      p_q  <= (point_w == '0) ? 17'd1 : {1'b0, point_w};
      cb_q <= black_w; cg_q <= grey_w; cw_q <= white_w;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_alpha
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en_w[0]) a_q[0] <= in_data_i.in_alpha;
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en_w[k]) a_q[k] <= a_q[k-1];
      end
    end
  end

  logic [7:0] ch_w [3];
  for (genvar c = 0; c < 3; c++) begin : g_ch
    ltct_chan #(.ColorFracBits(CW)) u_chan (
      .clk_i, .en_i(en_w[NS-1:1]), .y_i(y_q), .p_i(p_q),
      .cb_i(cb_q[(2-c)*CW +: CW]), .cg_i(cg_q[(2-c)*CW +: CW]),
      .cw_i(cw_q[(2-c)*CW +: CW]), .q_o(ch_w[c])
    );
  end

  assign out_valid_o          = vld_q[NS-1];
  assign out_data_o.out_red   = ch_w[0];
  assign out_data_o.out_green = ch_w[1];
  assign out_data_o.out_blue  = ch_w[2];
  assign out_data_o.out_alpha = a_q[NS-1];
endmodule
`default_nettype wire

// ===== rtl/ltct_regs.sv =====
// Configuration register file for the luma tint.
`default_nettype none
module ltct_regs #(
  parameter int unsigned ColorFracBits = ltct_pkg::ColorFracBits
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  ltct_pkg::cfg_beat_t        cfg_i,
  output logic [3*ColorFracBits-1:0] black_o,
  output logic [3*ColorFracBits-1:0] grey_o,
  output logic [3*ColorFracBits-1:0] white_o,
  output logic [15:0]                point_o
);
  import ltct_pkg::*;
  localparam int unsigned RegW = 3 * ColorFracBits;

  // Reset defaults are 16-bit fields; rescale each to the field width.
  function automatic logic [RegW-1:0] scale(input logic [47:0] v);
    logic [RegW-1:0] r;
    r = '0;
    for (int c = 0; c < 3; c++) begin
      if (ColorFracBits >= 16) begin
        r[c*ColorFracBits +: ColorFracBits] =
          ColorFracBits'({v[c*16 +: 16], {(ColorFracBits-15){1'b0}}} >> 1);
      end else begin
        r[c*ColorFracBits +: ColorFracBits] =
          ColorFracBits'(v[c*16 +: 16] >> (16 - ColorFracBits));
      end
    end
    return r;
  endfunction

  logic [RegW-1:0] black_q, grey_q, white_q;
  logic [15:0]     point_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      black_q <= scale(BlackReset);
      grey_q  <= scale(GreyReset);
      white_q <= scale(WhiteReset);
      point_q <= PointReset;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_i.idx))
        REG_BLACK: black_q <= cfg_i.data[RegW-1:0];
        REG_GREY:  grey_q  <= cfg_i.data[RegW-1:0];
        REG_WHITE: white_q <= cfg_i.data[RegW-1:0];
        REG_POINT: point_q <= cfg_i.data[15:0];
        default:   ;
      endcase
    end
  end

  assign black_o = black_q;
  assign grey_o  = grey_q;
  assign white_o = white_q;
  assign point_o = point_q;
endmodule
`default_nettype wire

// ===== rtl/ltct_chan.sv =====
// One channel of the tint pipeline: curve terms, sum, and restoring quotient.
`default_nettype none
module ltct_chan #(
  parameter int unsigned ColorFracBits = ltct_pkg::ColorFracBits
) (
  input  logic                     clk_i,
  input  logic [8:0]               en_i,   // per-stage advance
  input  logic [7:0]               y_i,
  input  logic [16:0]              p_i,
  input  logic [ColorFracBits-1:0] cb_i,
  input  logic [ColorFracBits-1:0] cg_i,
  input  logic [ColorFracBits-1:0] cw_i,
  output logic [7:0]               q_o
);
  localparam int unsigned CW  = ColorFracBits;
  localparam int unsigned AW  = 25;           // |Y*65536 - 255*P|
  localparam int unsigned SW  = 66 + CW;      // signed sum width
  localparam int unsigned DW  = 41 + CW;      // denominator width
  localparam logic [CW-1:0] FMask = '1;

  // Stage 1: geometry of the point.
  logic [AW-1:0] d_q;
  logic          dneg_q;
  logic [7:0]    y1_q, ny1_q;
  logic [16:0]   p1_q, sp1_q;
  logic [CW-1:0] cb1_q, cg1_q, cw1_q;
  logic [AW-1:0] ys_w, pp_w;
  assign ys_w = AW'({y_i, 16'd0});
  assign pp_w = AW'(p_i) * AW'(255);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      dneg_q <= ys_w < pp_w;
      d_q    <= (ys_w < pp_w) ? pp_w - ys_w : ys_w - pp_w;
      y1_q   <= y_i;
      ny1_q  <= 8'd255 - y_i;
      p1_q   <= p_i;
      sp1_q  <= 17'h10000 - p_i;
      cb1_q  <= cb_i; cg1_q <= cg_i; cw1_q <= cw_i;
    end
  end

  // Stage 2: first products.
  logic [32:0] a0_q;      // d*ny
  logic [15:0] a1_q;      // y*ny
  logic [32:0] a2_q;      // y*d
  logic [16:0] sp2_q, p2_q;
  logic        dneg2_q;
  logic [CW-1:0] cb2_q, cg2_q, cw2_q;
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      a0_q <= 33'(d_q) * 33'(ny1_q);
      a1_q <= 16'(y1_q) * 16'(ny1_q);
      a2_q <= 33'(d_q) * 33'(y1_q);
      sp2_q <= sp1_q; p2_q <= p1_q; dneg2_q <= dneg_q;
      cb2_q <= cb1_q; cg2_q <= cg1_q; cw2_q <= cw1_q;
    end
  end

  // Stage 3: times the point factors, and the denominator base.
  logic [49:0] b0_q, b2_q;
  logic [15:0] b1_q;
  logic [32:0] pd_q;      // P*S
  logic        dneg3_q;
  logic [CW-1:0] cb3_q, cg3_q, cw3_q;
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      b0_q <= 50'(a0_q) * 50'(sp2_q);
      b2_q <= 50'(a2_q) * 50'(p2_q);
      b1_q <= a1_q;
      pd_q <= 33'(p2_q) * 33'(sp2_q);
      dneg3_q <= dneg2_q;
      cb3_q <= cb2_q; cg3_q <= cg2_q; cw3_q <= cw2_q;
    end
  end

  // Stage 4: times the colors.
  logic [SW-1:0] t0_q, t1_q, t2_q;
  logic          dneg4_q;
  logic [DW-1:0] den4_q;
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      t0_q <= SW'(b0_q) * SW'(cb3_q);
      t1_q <= SW'({b1_q, 32'd0}) * SW'(cg3_q);
      t2_q <= SW'(b2_q) * SW'(cw3_q);
      dneg4_q <= dneg3_q;
      den4_q <= DW'(pd_q) * DW'(255) * DW'(FMask);
    end
  end

  // Stage 5: signed sum.
  logic signed [SW:0] s_w;
  logic [SW-1:0] sum_q;
  logic          neg_q;
  logic [DW-1:0] den5_q;
  always_comb begin
    s_w = $signed({1'b0, t1_q});
    s_w = dneg4_q ? s_w + $signed({1'b0, t0_q}) : s_w - $signed({1'b0, t0_q});
    s_w = dneg4_q ? s_w - $signed({1'b0, t2_q}) : s_w + $signed({1'b0, t2_q});
  end
  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      neg_q  <= s_w[SW];
      sum_q  <= s_w[SW-1:0];
      den5_q <= den4_q;
    end
  end

  // Stages 6..9: two quotient bits per stage, restoring.
  logic [SW-1:0] rem_q [4];
  logic [7:0]    qq_q  [4];
  logic [DW-1:0] dn_q  [4];
  logic          ng_q  [4];
  for (genvar s = 0; s < 4; s++) begin : g_div
    logic [SW-1:0] r_in, r_mid, r_out;
    logic [7:0]    q_in, q_out;
    logic [DW-1:0] dn_in;
    logic          ng_in;
    logic [SW+7:0] c1, c0;
    if (s == 0) begin : g_f
      assign r_in = sum_q; assign q_in = '0; assign dn_in = den5_q;
      assign ng_in = neg_q;
    end else begin : g_n
      assign r_in = rem_q[s-1]; assign q_in = qq_q[s-1]; assign dn_in = dn_q[s-1];
      assign ng_in = ng_q[s-1];
    end
    always_comb begin
      c1 = (SW+8)'(dn_in) << (7 - 2*s);
      c0 = (SW+8)'(dn_in) << (6 - 2*s);
      q_out = q_in;
      r_mid = r_in;
      if ((SW+8)'(r_in) >= c1) begin
        r_mid = r_in - SW'(c1);
        q_out[7-2*s] = 1'b1;
      end
      r_out = r_mid;
      if ((SW+8)'(r_mid) >= c0) begin
        r_out = r_mid - SW'(c0);
        q_out[6-2*s] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i[5+s]) begin
        rem_q[s] <= r_out;
        qq_q[s]  <= q_out;
        dn_q[s]  <= dn_in;
        ng_q[s]  <= ng_in;
      end
    end
  end

  assign q_o = ng_q[3] ? 8'd0 : qq_q[3];
endmodule
`default_nettype wire

// ===== rtl/ltct_checker.sv =====
// Port-level checker for the luma tint, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module ltct_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ltct_pkg::pix_out_t  out_data_o
);
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "out valid dropped")
  `ASSERT_CLK(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i |=> $stable(out_data_o), "out beat changed")
  `ASSERT_CLK(a_ready_free, clk_i, rst_ni, out_ready_i |-> in_ready_o, "input stalled with free output")
  `ASSERT_KNOWN(a_out_known, clk_i, rst_ni, out_valid_o ? out_data_o : '0, "unknown out beat")
endmodule

bind luma_three_color_tint ltct_checker u_ltct_checker (
  .clk_i, .rst_ni, .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o
);
`default_nettype wire

// ===== tb/luma_three_color_tint_tb.sv =====
// Testbench for the three-color luma tint: random pixels and settings checked against a predictor.
`timescale 1ns / 1ps
module luma_three_color_tint_tb;
  import ltct_pkg::*;

  localparam int unsigned WatchLimit = 4000;
  localparam int unsigned DrainCycles = 20;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  pix_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  pix_out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  cfg_beat_t cfg_data_i = '0;

  luma_three_color_tint dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i, .out_valid_o, .out_ready_i,
    .out_data_o, .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor copy of the registers
  logic [47:0] black_q, grey_q, white_q;
  logic [15:0] point_q;

  pix_in_t pixel_q[$];
  pix_out_t tinted_q[$];
  int unsigned mismatches = 0;
  int unsigned pixels_sent = 0;
  int unsigned pixels_seen = 0;
  int unsigned cfg_writes = 0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  bit in_taken = 1'b0;
  bit hold_sink = 1'b0;
  int unsigned idle_cycles = 0;

  function automatic logic [7:0] tint_channel(int unsigned y, logic [15:0] p,
                                              logic [15:0] cb, logic [15:0] cg,
                                              logic [15:0] cw);
    logic signed [127:0] a, b, c, num, den;
    logic signed [127:0] ys, pp, s, k;
    begin
      s = 65536 - p;
      ys = y * 65536;
      pp = 255 * p;
      // Lagrange weights scaled by 255*p*s*(2^16-1)
      a = (ys - pp) * (y - 255) * s * cb;
      b = y * (255 - y) * 65536 * 65536 * cg;
      c = y * (ys - pp) * p * cw;
      num = a + b + c;
      if (num < 0) return 8'd0;
      den = 255 * p * s * 65535;
      k = num / den;
      return (k > 255) ? 8'd255 : k[7:0];
    end
  endfunction

  function automatic pix_out_t tint_pixel(pix_in_t px);
    pix_out_t r;
    int unsigned y;
    logic [15:0] p;
    begin
      y = (299 * px.in_red + 587 * px.in_green + 114 * px.in_blue) / 1000;
      p = (point_q == 0) ? 16'd1 : point_q;
      r.out_red = tint_channel(y, p, black_q[47:32], grey_q[47:32], white_q[47:32]);
      r.out_green = tint_channel(y, p, black_q[31:16], grey_q[31:16], white_q[31:16]);
      r.out_blue = tint_channel(y, p, black_q[15:0], grey_q[15:0], white_q[15:0]);
      r.out_alpha = px.in_alpha;
      return r;
    end
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH %s: got %0d want %0d (pixel %0d)", what, got, want, pixels_seen);
    mismatches++;
  endtask

  // Driver: advance to the next pixel only after the current beat was taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (pixel_q.size() > 0 && in_gap == 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= pixel_q[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= (out_gap == 0) && !hold_sink;
    end
  end

  // Monitor: accept beats, predict and compare
  always @(posedge clk_i) begin
    pix_out_t want;
    bit busy;
    if (rst_ni) begin
      busy = (in_valid_i && in_ready_o) || (cfg_valid_i && cfg_ready_o)
          || (out_valid_o && out_ready_i);
      idle_cycles <= busy ? 0 : idle_cycles + 1;
      in_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        tinted_q.push_back(tint_pixel(pixel_q.pop_front()));
        pixels_sent++;
      end
      if (out_valid_o && out_ready_i) begin
        pixels_seen++;
        if (tinted_q.size() == 0) begin
          report_mismatch("unexpected beat", out_data_o, 0);
        end else begin
          want = tinted_q.pop_front();
          if (out_data_o.out_red !== want.out_red)
            report_mismatch("red", out_data_o.out_red, want.out_red);
          if (out_data_o.out_green !== want.out_green)
            report_mismatch("green", out_data_o.out_green, want.out_green);
          if (out_data_o.out_blue !== want.out_blue)
            report_mismatch("blue", out_data_o.out_blue, want.out_blue);
          if (out_data_o.out_alpha !== want.out_alpha)
            report_mismatch("alpha", out_data_o.out_alpha, want.out_alpha);
        end
      end
      if (idle_cycles >= WatchLimit) begin
        $display("watchdog: no beat for %0d cycles", WatchLimit);
        $display("luma_three_color_tint test failed");
        $finish;
      end
    end
  end

  // Random idle bursts on both sides, none started in the calm phase
  bit calm = 1'b0;
  always @(negedge clk_i) begin
    if (in_gap != 0) begin
      in_gap <= in_gap - 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      in_gap <= $urandom_range(1, 15);
    end
    if (out_gap != 0) begin
      out_gap <= out_gap - 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_gap <= $urandom_range(1, 15);
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [47:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= '{idx: idx, data: value};
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_BLACK: black_q = value;
      REG_GREY: grey_q = value;
      REG_WHITE: white_q = value;
      REG_POINT: point_q = value[15:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pixel_q.size() > 0 || tinted_q.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [47:0] rand_color();
    logic [47:0] v;
    begin
      v = 48'({$urandom, $urandom});
      case ($urandom_range(0, 3))
        0: v = '0;
        1: v = '1;
        default: ;
      endcase
      return v;
    end
  endfunction

  task automatic queue_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
    pixel_q.push_back('{in_red: r, in_green: g, in_blue: b, in_alpha: a});
  endtask

  task automatic queue_random(int unsigned n);
    repeat (n) queue_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  initial begin
    black_q = BlackReset;
    grey_q = GreyReset;
    white_q = WhiteReset;
    point_q = PointReset;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: luma extremes, around the grey point, alpha extremes
    queue_pixel(8'd0, 8'd0, 8'd0, 8'd0);
    queue_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    queue_pixel(8'd128, 8'd128, 8'd128, 8'd170);
    queue_pixel(8'd127, 8'd127, 8'd127, 8'd85);
    queue_pixel(8'd255, 8'd0, 8'd0, 8'd1);
    queue_pixel(8'd0, 8'd255, 8'd0, 8'd254);
    queue_pixel(8'd0, 8'd0, 8'd255, 8'd128);
    queue_pixel(8'd1, 8'd2, 8'd3, 8'd127);
    drain();

    // Grey point extremes and zero; saturated colors provoke overshoot
    write_reg(REG_POINT, 48'd0);
    write_reg(REG_BLACK, '0);
    write_reg(REG_GREY, '1);
    write_reg(REG_WHITE, '0);
    queue_pixel(8'd0, 8'd0, 8'd0, 8'd9);
    queue_pixel(8'd1, 8'd1, 8'd1, 8'd9);
    queue_pixel(8'd200, 8'd90, 8'd30, 8'd9);
    queue_pixel(8'd255, 8'd255, 8'd255, 8'd9);
    drain();
    write_reg(REG_POINT, 48'd65535);
    write_reg(REG_GREY, '0);
    write_reg(REG_WHITE, '1);
    queue_pixel(8'd254, 8'd254, 8'd254, 8'd3);
    queue_pixel(8'd255, 8'd254, 8'd255, 8'd3);
    queue_pixel(8'd100, 8'd100, 8'd100, 8'd3);
    queue_pixel(8'd255, 8'd255, 8'd255, 8'd3);
    drain();
    write_reg(REG_POINT, 48'd1);
    queue_pixel(8'd0, 8'd0, 8'd0, 8'd4);
    queue_pixel(8'd1, 8'd1, 8'd1, 8'd4);
    queue_pixel(8'd255, 8'd255, 8'd255, 8'd4);
    drain();

    // Random phases with fresh settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_BLACK, rand_color());
      write_reg(REG_GREY, rand_color());
      write_reg(REG_WHITE, rand_color());
      write_reg(REG_POINT, 48'($urandom_range(0, 65535)));
      queue_random(60);
      if (ph == 2) begin
        // Long receiver hold-off so the pipeline fills and stalls its input
        fork begin
          hold_sink = 1'b1;
          repeat (200) @(posedge clk_i);
          hold_sink = 1'b0;
        end join_none
      end
      drain();
    end

    // Calm tail: back-to-back beats at reset colors
    calm = 1'b1;
    write_reg(REG_BLACK, BlackReset);
    write_reg(REG_GREY, GreyReset);
    write_reg(REG_WHITE, WhiteReset);
    write_reg(REG_POINT, 48'(PointReset));
    queue_random(60);
    drain();

    $display("Sent %0d and checked %0d pixels over %0d register writes, with grey point",
             pixels_sent, pixels_seen, cfg_writes);
    $display("extremes, clamped overshoot, idle bursts, a long output stall and a busy tail.");
    if (mismatches == 0) begin
      $display("luma_three_color_tint test passed");
    end else begin
      $display("luma_three_color_tint test failed");
    end
    $finish;
  end

endmodule
